/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// checked only outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* hdl/sbap_pkg.sv */
// ----------------------------------------------------------------------------
// sbap_pkg
// Types, constants and the armour decode for the six-bit packer.
// ----------------------------------------------------------------------------
package sbap_pkg;

  localparam int unsigned SYM_BITS    = 6;
  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned BITS_W      = 12;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned MAX_FILL    = 5;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_last;
    logic [11:0] payload_bits;
  } res_t;

  // bytes produced by one character: zero, one or two
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } push_t;

  // 48..87 -> c-48, 96..119 -> c-56, everything else 0
  function automatic logic [5:0] armour_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= 8'd48 && c <= 8'd87) begin
      d = c - 8'd48;
    end else if (c >= 8'd96 && c <= 8'd119) begin
      d = c - 8'd56;
    end
    return d[5:0];
  endfunction

endpackage

/* hdl/sbap_packer.sv */
// ----------------------------------------------------------------------------
// sbap_packer
// Decodes one registered character, packs its six bits into bytes and keeps
// the pending bits and the character count of the current payload.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbap_packer #(
  parameter int unsigned MAX_CHARS = 512
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  logic [7:0]      char_code,
  input  logic [2:0]      fill_bits,
  input  logic            is_last,
  output sbap_pkg::push_t push
);
  import sbap_pkg::*;

  localparam int unsigned CW = $clog2(MAX_CHARS + 1);
  localparam int unsigned TW = (CW + 3 > BITS_W) ? CW + 3 : BITS_W;

  logic [5:0]    pending_bits, pending_bits_next;
  logic [2:0]    pending_count, pending_count_next;
  logic [CW-1:0] char_count, char_count_next;

  logic [5:0]    sym;
  logic [11:0]   acc, acc_rem;
  logic [3:0]    n_full;
  logic [2:0]    n_left;
  logic          emit_full;
  logic [7:0]    byte_full, byte_flush;
  logic [CW-1:0] cnt_inc;
  logic [2:0]    fill_c;
  logic [TW-1:0] total;
  logic [11:0]   total_sat;

  always_comb begin
    sym       = armour_value(char_code);
    acc       = {pending_bits, sym};
    n_full    = {1'b0, pending_count} + 4'(SYM_BITS);
    emit_full = n_full >= 4'(BYTE_BITS);
    n_left    = emit_full ? 3'(n_full - 4'(BYTE_BITS)) : n_full[2:0];
    byte_full = 8'(acc >> n_left);
    acc_rem   = acc & ((12'd1 << n_left) - 12'd1);
    // leftover bits go to the top of the flush byte, zero padded below
    byte_flush = 8'(acc_rem << (4'(BYTE_BITS) - {1'b0, n_left}));

    cnt_inc = (char_count < CW'(MAX_CHARS)) ? char_count + 1'b1 : char_count;
    fill_c  = (fill_bits > 3'(MAX_FILL)) ? 3'(MAX_FILL) : fill_bits;
    total   = (TW'(cnt_inc) << 2) + (TW'(cnt_inc) << 1) - TW'(fill_c);
    total_sat = (total > TW'({BITS_W{1'b1}})) ? {BITS_W{1'b1}} : total[11:0];

    push = '0;
    if (emit_full) begin
      push.num          = 2'd1;
      push.r0.data_byte = byte_full;
      if (is_last) begin
        if (n_left != 3'd0) begin
          push.num             = 2'd2;
          push.r1.data_byte    = byte_flush;
          push.r1.byte_last    = 1'b1;
          push.r1.payload_bits = total_sat;
        end else begin
          push.r0.byte_last    = 1'b1;
          push.r0.payload_bits = total_sat;
        end
      end
    end else if (is_last) begin
      push.num             = 2'd1;
      push.r0.data_byte    = byte_flush;
      push.r0.byte_last    = 1'b1;
      push.r0.payload_bits = total_sat;
    end
    if (!fire) begin
      push.num = 2'd0;
    end

    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    char_count_next    = char_count;
    if (fire) begin
      if (is_last) begin
        pending_bits_next  = '0;
        pending_count_next = '0;
        char_count_next    = '0;
      end else begin
        pending_bits_next  = acc_rem[5:0];
        pending_count_next = n_left;
        char_count_next    = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
      char_count    <= '0;
    end else begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
      char_count    <= char_count_next;
    end
  end

  `ASSERT_CLK(a_pend_even, clk, rst,
              pending_count[0] == 1'b0 && pending_count != 3'd7, "odd pending count")
  `ASSERT_CLK(a_last_clears, clk, rst,
              (fire && is_last) |=> (pending_count == 3'd0 && char_count == '0),
              "state not cleared after last")
  `ASSERT_CLK(a_last_emits, clk, rst,
              (fire && is_last) |-> (push.num != 2'd0), "last character gave no byte")
  `ASSERT_CLK(a_cnt_bound, clk, rst, char_count <= CW'(MAX_CHARS), "char count past bound")

endmodule

/* hdl/sbap_out_queue.sv */
// ----------------------------------------------------------------------------
// sbap_out_queue
// Small result queue: takes up to two words per cycle, hands out one unless stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbap_out_queue (
  input  logic            clk,
  input  logic            rst,
  input  sbap_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_stall,
  output sbap_pkg::res_t  head
);
  import sbap_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

  res_t          mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] count, count_next;
  logic          pop;

  assign room      = count <= NW'(QUEUE_DEPTH - 2);
  assign out_valid = count != '0;
  assign head      = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    count_next = count + NW'(push.num) - NW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.num);
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.num == 2'd2) begin
      mem[PW'(wr_ptr + 1'b1)] <= push.r1;
    end
  end

  `ASSERT_CLK(a_cnt_max, clk, rst, count <= NW'(QUEUE_DEPTH), "queue count overflow")
  `ASSERT_CLK(a_push_room, clk, rst, (push.num != 2'd0) |-> room, "push without room")
  `ASSERT_CLK(a_cnt_step, clk, rst,
              (push.num == 2'd0 && !pop) |=> $stable(count), "count moved while idle")

endmodule

/* hdl/six_bit_armour_bit_packer.sv */
// ----------------------------------------------------------------------------
// six_bit_armour_bit_packer
// Six-bit armour decoder and MSB-first byte packer.
// ----------------------------------------------------------------------------
// One armoured character is taken per cycle into an input register while
// in_stall is low; it is then decoded, packed and its bytes (none, one or two)
// are written to a four-word result queue once it has room, one word leaving
// per cycle while out_stall is low. A character that makes one byte or none
// sustains one character per cycle while the output does not stall; the last
// character of a payload may make two words, so the output port, one word per
// cycle, sets the rate then. The final word carries byte_last and the payload
// bit count, characters * 6 minus fill bits, with the character count saturating at MAX_CHARS.
module six_bit_armour_bit_packer #(
  parameter int unsigned MAX_CHARS = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic [2:0]  fill_bits,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  data_byte,
  output logic        byte_last,
  output logic [11:0] payload_bits
);
  import sbap_pkg::*;

  logic       in_q_valid;
  logic [7:0] char_q;
  logic [2:0] fill_q;
  logic       last_q;
  logic       room, fire;
  push_t      push;
  res_t       head;

  assign fire     = in_q_valid && room;
  assign in_stall = in_q_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      char_q <= char_code;
      fill_q <= fill_bits;
      last_q <= is_last;
    end
  end

  sbap_packer #(
    .MAX_CHARS(MAX_CHARS)
  ) u_packer (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .char_code (char_q),
    .fill_bits (fill_q),
    .is_last   (last_q),
    .push      (push)
  );

  sbap_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign data_byte    = head.data_byte;
  assign byte_last    = head.byte_last;
  assign payload_bits = head.payload_bits;

endmodule

/* dv/byte_stream_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stream_checker
// Watches both channels of the six-bit packer, predicts the packed bytes of
// each accepted character and compares every word that leaves the block.
// ----------------------------------------------------------------------------
module byte_stream_checker #(
  parameter int unsigned MAX_CHARS = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic [2:0]  fill_bits,
  input  logic        is_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_last,
  input  logic [11:0] payload_bits,
  output int unsigned mismatches,
  output int unsigned outstanding,
  output int unsigned compared
);
  import sbap_pkg::*;

  res_t        expected_bytes[$];
  logic [5:0]  held_bits;
  int unsigned held_count;
  int unsigned chars_seen;

  function automatic logic [5:0] sixbit(input logic [7:0] c);
    if (c >= 8'd48 && c <= 8'd87) begin
      return 6'(c - 8'd48);
    end
    if (c >= 8'd96 && c <= 8'd119) begin
      return 6'(c - 8'd56);
    end
    return 6'd0;
  endfunction

  task automatic pack_char(input logic [7:0] c, input logic [2:0] f, input logic l);
    logic [11:0] acc;
    int unsigned n;
    int unsigned pad;
    int unsigned total;
    res_t        made[2];
    int          k;
    k   = 0;
    acc = {held_bits, sixbit(c)};
    n   = held_count + SYM_BITS;
    if (chars_seen < MAX_CHARS) chars_seen++;
    if (n >= BYTE_BITS) begin
      n = n - BYTE_BITS;
      made[k] = '0;
      made[k].data_byte = 8'(acc >> n);
      k++;
      acc = acc & ((12'd1 << n) - 12'd1);
    end
    held_bits  = acc[5:0];
    held_count = n;
    if (l) begin
      pad = (f > MAX_FILL) ? MAX_FILL : f;
      // leftover bits go out left aligned, zero padded
      if (n > 0) begin
        made[k] = '0;
        made[k].data_byte = 8'(acc << (BYTE_BITS - n));
        k++;
      end
      total = chars_seen * SYM_BITS - pad;
      if (total > 4095) total = 4095;
      made[k-1].byte_last    = 1'b1;
      made[k-1].payload_bits = 12'(total);
      held_bits  = '0;
      held_count = 0;
      chars_seen = 0;
    end
    for (int i = 0; i < k; i++) expected_bytes.insert(expected_bytes.size(), made[i]);
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    logic bad;
    if (rst) begin
      expected_bytes.delete();
      held_bits  = '0;
      held_count = 0;
      chars_seen = 0;
    end else begin
      if (in_valid && !in_stall) pack_char(char_code, fill_bits, is_last);
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected word data_byte %02h byte_last %0b payload_bits %0d",
                   $time, data_byte, byte_last, payload_bits);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          bad  = 1'b0;
          if (data_byte !== want.data_byte) begin
            $display("%0t: data_byte expected %02h actual %02h",
                     $time, want.data_byte, data_byte);
            bad = 1'b1;
          end
          if (byte_last !== want.byte_last) begin
            $display("%0t: byte_last expected %0b actual %0b",
                     $time, want.byte_last, byte_last);
            bad = 1'b1;
          end
          if (payload_bits !== want.payload_bits) begin
            $display("%0t: payload_bits expected %0d actual %0d",
                     $time, want.payload_bits, payload_bits);
            bad = 1'b1;
          end
          if (bad) mismatches++;
          compared++;
        end
      end
    end
    outstanding = expected_bytes.size();
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives armoured characters into the six-bit packer: a directed set of
// short payloads over the character ranges and fill values, then random
// payloads including one of MAX_CHARS characters and one long enough to saturate the character count, with
// random idling on both sides. Checking is done by byte_stream_checker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned MAX_CHARS = 512;
  localparam int unsigned ITEMS     = 1850;
  localparam int unsigned HOLD      = 300;
  localparam int unsigned LIMIT     = 1000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_code = 8'd0;
  logic [2:0]  fill_bits = 3'd0;
  logic        is_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  data_byte;
  logic        byte_last;
  logic [11:0] payload_bits;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned compared;

  int unsigned cycles = 0;
  int unsigned n_items = 0;
  int unsigned n_payloads = 0;
  int unsigned cur_len = 0;
  int unsigned longest = 0;
  int unsigned tx_calm = 0;
  int unsigned rx_calm = 0;
  bit          hold_req = 1'b0;

  six_bit_armour_bit_packer #(.MAX_CHARS(MAX_CHARS)) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_code    (char_code),
    .fill_bits    (fill_bits),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_byte    (data_byte),
    .byte_last    (byte_last),
    .payload_bits (payload_bits)
  );

  byte_stream_checker #(.MAX_CHARS(MAX_CHARS)) u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_code    (char_code),
    .fill_bits    (fill_bits),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .data_byte    (data_byte),
    .byte_last    (byte_last),
    .payload_bits (payload_bits),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .compared     (compared)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 4))
      0, 1: return 8'($urandom_range(48, 87));
      2: return 8'($urandom_range(96, 119));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int unsigned payload_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return $urandom_range(1, 8);
    if (p < 90) return $urandom_range(9, 40);
    return $urandom_range(41, 168);
  endfunction

  task automatic send_char(input logic [7:0] c, input logic [2:0] f, input logic l);
    int unsigned gap;
    if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 49) == 0) tx_calm = $urandom_range(20, 120);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    fill_bits <= f;
    is_last   <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
    cur_len++;
    if (l) begin
      n_payloads++;
      if (cur_len > longest) longest = cur_len;
      cur_len = 0;
    end
  endtask

  // fill bits are random on every character; the block only reads them on the last
  task automatic send_payload(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_char(rand_char(), 3'($urandom_range(0, 7)), i == len - 1);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // receiver: random stalls, calm stretches, and one long hold on request
  initial begin : rx_side
    int unsigned n;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n = HOLD;
      end else if (rx_calm > 0) begin
        rx_calm--;
        n = 0;
      end else begin
        n = idle_len();
        if ($urandom_range(0, 49) == 0) rx_calm = $urandom_range(20, 150);
      end
      out_stall <= (n > 0);
      repeat ((n > 0) ? n : 1) @(posedge clk);
      if (n > 0) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned len;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // one character: flushed as a single zero-padded final byte
    send_char(8'd0, 3'd0, 1'b1);
    send_char(8'd48, 3'd1, 1'b0);
    send_char(8'd87, 3'd5, 1'b1);
    // stray codes between the two ranges, fill above the maximum
    send_char(8'd88, 3'd6, 1'b0);
    send_char(8'd95, 3'd3, 1'b0);
    send_char(8'd96, 3'd7, 1'b1);
    // four characters end on a byte boundary: no flush word
    send_char(8'd119, 3'd7, 1'b0);
    send_char(8'd120, 3'd0, 1'b0);
    send_char(8'd255, 3'd5, 1'b0);
    send_char(8'd47, 3'd2, 1'b1);
    send_char(8'd119, 3'd0, 1'b0);
    send_char(8'd119, 3'd0, 1'b0);
    send_char(8'd119, 3'd0, 1'b0);
    send_char(8'd119, 3'd0, 1'b0);
    send_char(8'd119, 3'd3, 1'b1);
    send_char(8'd63, 3'd7, 1'b0);
    send_char(8'd128, 3'd1, 1'b0);
    send_char(8'd100, 3'd6, 1'b1);
    send_char(8'd119, 3'd4, 1'b1);
    send_char(8'd87, 3'd0, 1'b1);
    drain();

    while (n_items < ITEMS) begin
      if (n_payloads == 12) len = MAX_CHARS;
      else if (n_payloads == 30) len = MAX_CHARS + 17;
      else len = payload_len();
      // long receiver hold while words keep coming
      if (n_payloads == 20) hold_req = 1'b1;
      if (n_payloads == 45) drain();
      send_payload(len);
    end
    drain();
    repeat (10) @(posedge clk);

    $display("%0d characters in %0d payloads, longest %0d characters",
             n_items, n_payloads, longest);
    $display("%0d bytes compared, %0d mismatches", compared, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
